### hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds on every clock outside reset
`define BMS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// same-cycle implication
`define BMS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define BMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/bms_pkg.sv
// shared constants and types of the byte merge sorter
// no dependencies
package bms_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int BYTE_W       = 8;

   // commands from the sequencer to the merge core
   typedef struct packed {
      logic start;   // begin sorting the stored run
      logic rd_en;   // read one sorted entry for the output
   } bms_ctl_type;

endpackage

### hdl/bms_merge_core.sv
// merge core: two ping-pong byte memories and the bottom-up merge sequencer
// depends on bms_pkg
module bms_merge_core #(
   parameter int CAPACITY = bms_pkg::CAPACITY_DEF,
   localparam int IW = $clog2(CAPACITY),
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bms_pkg::bms_ctl_type      ctl,
   input  logic [CW-1:0]             count,
   input  logic                      wr_en,
   input  logic [IW-1:0]             wr_addr,
   input  logic [bms_pkg::BYTE_W-1:0] wr_data,
   input  logic [IW-1:0]             rd_addr,
   output logic [bms_pkg::BYTE_W-1:0] rd_data,
   output logic                      done
);
   import bms_pkg::*;

   localparam int WW = CW + 1;   // merge width can exceed the count, but stays below twice it
   localparam int PW = CW + 2;   // block bound sums before clamping

   typedef enum logic [1:0] {E_IDLE, E_PASS, E_BLOCK, E_MERGE} eng_state_type;

   eng_state_type state_ff;
   logic [CW-1:0] n_ff, lo_ff, mid_ff, hi_ff, a_ff, b_ff, k_ff;
   logic [WW-1:0] width_ff;
   logic          src_sel_ff;   // 0: source is memory a
   logic          fin_sel_ff;   // buffer that holds the sorted run
   logic          rsel_ff;      // buffer selected for the read in flight
   logic          done_ff;

   logic [BYTE_W-1:0] mem_a [CAPACITY];
   logic [BYTE_W-1:0] mem_b [CAPACITY];
   logic [BYTE_W-1:0] a_ra_ff, a_rb_ff, b_ra_ff, b_rb_ff;

   logic [PW-1:0]     mid_sum, hi_sum, n_ext;
   logic [CW-1:0]     mid_c, hi_c;
   logic [BYTE_W-1:0] va, vb, wr_val;
   logic              take_a;
   logic [CW-1:0]     a_nx, b_nx, k_nx;
   logic [CW-1:0]     ra_pos, rb_pos;
   logic              rd_go;
   logic              mem_a_we, mem_b_we;
   logic [IW-1:0]     mem_a_waddr;
   logic [BYTE_W-1:0] mem_a_wdata;

   assign n_ext   = PW'(n_ff);
   assign mid_sum = PW'(lo_ff) + PW'(width_ff);
   assign hi_sum  = PW'(lo_ff) + PW'({width_ff, 1'b0});
   assign mid_c   = (mid_sum > n_ext) ? n_ff : mid_sum[CW-1:0];
   assign hi_c    = (hi_sum > n_ext) ? n_ff : hi_sum[CW-1:0];

   assign va     = rsel_ff ? b_ra_ff : a_ra_ff;
   assign vb     = rsel_ff ? b_rb_ff : a_rb_ff;
   // left head wins unless used up or the remaining right head is smaller or equal
   assign take_a = (a_ff < mid_ff) && ((b_ff >= hi_ff) || (va < vb));
   assign wr_val = take_a ? va : vb;
   assign a_nx   = a_ff + CW'(take_a);
   assign b_nx   = b_ff + CW'(!take_a);
   assign k_nx   = k_ff + CW'(1);

   // heads for the next compare are fetched while this one is written
   always_comb begin
      case (state_ff)
         E_BLOCK: begin
            ra_pos = lo_ff;
            rb_pos = mid_c;
         end
         E_MERGE: begin
            ra_pos = a_nx;
            rb_pos = b_nx;
         end
         default: begin
            ra_pos = CW'(rd_addr);
            rb_pos = '0;
         end
      endcase
   end

   assign rd_go = (state_ff != E_IDLE) || ctl.rd_en;

   // source and destination are always different memories, so no forwarding
   assign mem_a_we    = (state_ff == E_MERGE) ? src_sel_ff : wr_en;
   assign mem_a_waddr = (state_ff == E_MERGE) ? k_ff[IW-1:0] : wr_addr;
   assign mem_a_wdata = (state_ff == E_MERGE) ? wr_val : wr_data;
   assign mem_b_we    = (state_ff == E_MERGE) && !src_sel_ff;

   always_ff @(posedge clock) begin
      if (mem_a_we) begin
         mem_a[mem_a_waddr] <= mem_a_wdata;
      end
      if (mem_b_we) begin
         mem_b[k_ff[IW-1:0]] <= wr_val;
      end
      if (rd_go) begin
         a_ra_ff <= mem_a[ra_pos[IW-1:0]];
         a_rb_ff <= mem_a[rb_pos[IW-1:0]];
         b_ra_ff <= mem_b[ra_pos[IW-1:0]];
         b_rb_ff <= mem_b[rb_pos[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= E_IDLE;
         src_sel_ff <= 1'b0;
         fin_sel_ff <= 1'b0;
         rsel_ff    <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         rsel_ff <= (state_ff == E_IDLE) ? fin_sel_ff : src_sel_ff;
         case (state_ff)
            E_IDLE: begin
               if (ctl.start) begin
                  n_ff       <= count;
                  width_ff   <= WW'(1);
                  src_sel_ff <= 1'b0;
                  state_ff   <= E_PASS;
               end
            end
            E_PASS: begin
               if (WW'(n_ff) <= width_ff) begin
                  fin_sel_ff <= src_sel_ff;
                  done_ff    <= 1'b1;
                  state_ff   <= E_IDLE;
               end else begin
                  lo_ff    <= '0;
                  state_ff <= E_BLOCK;
               end
            end
            E_BLOCK: begin
               mid_ff   <= mid_c;
               hi_ff    <= hi_c;
               a_ff     <= lo_ff;
               b_ff     <= mid_c;
               k_ff     <= lo_ff;
               state_ff <= E_MERGE;
            end
            E_MERGE: begin
               a_ff <= a_nx;
               b_ff <= b_nx;
               k_ff <= k_nx;
               if (k_nx == hi_ff) begin
                  if (hi_ff == n_ff) begin
                     width_ff   <= {width_ff[WW-2:0], 1'b0};
                     src_sel_ff <= !src_sel_ff;
                     state_ff   <= E_PASS;
                  end else begin
                     lo_ff    <= hi_ff;
                     state_ff <= E_BLOCK;
                  end
               end
            end
            default: begin
               state_ff <= E_IDLE;
            end
         endcase
      end
   end

   assign rd_data = rsel_ff ? b_ra_ff : a_ra_ff;
   assign done    = done_ff;

endmodule

### hdl/byte_merge_sorter_unit.sv
// byte merge sorter top level: run collection, sort control and result beats
// depends on bms_pkg and bms_merge_core
//
//   channel | direction | beat contents
//   req     | in        | req_byte_in, req_last_in
//   rsp     | out       | rsp_byte_out, rsp_last_out, rsp_overflow
//
// collect: one req beat per cycle, stored to capacity, closed by req_last_in
// sort: ceil(log2 n) merge passes, each block set up and then merged,
//   one compare and one memory write per cycle with the heads read ahead
// output: each rsp beat is read, loaded and held until taken, one at a time;
//   req_ready is low from the closing beat until the final rsp beat is taken
// synchronous reset clears control only; memories need no clearing
module byte_merge_sorter_unit #(
   parameter int CAPACITY = bms_pkg::CAPACITY_DEF,
   localparam int IW = $clog2(CAPACITY),
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [bms_pkg::BYTE_W-1:0] req_byte_in,
   input  logic                       req_last_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [bms_pkg::BYTE_W-1:0] rsp_byte_out,
   output logic                       rsp_last_out,
   output logic                       rsp_overflow
);
   import bms_pkg::*;

   typedef enum logic [2:0] {S_COLLECT, S_SORT, S_READ, S_LOAD, S_SHOW} top_state_type;

   top_state_type     state_ff;
   logic [CW-1:0]     fill_ff, fill_in;
   logic              drop_ff;
   logic [CW-1:0]     out_k_ff;
   logic              rsp_valid_ff, rsp_last_ff, rsp_ovf_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;

   logic              accept, room;
   bms_ctl_type       ctl;
   logic [BYTE_W-1:0] rd_data;
   logic              sort_done;

   assign req_ready = (state_ff == S_COLLECT);
   assign accept    = req_valid && req_ready;
   assign room      = (fill_ff < CW'(CAPACITY));
   assign fill_in   = fill_ff + CW'(room);

   assign ctl.start = accept && req_last_in;
   assign ctl.rd_en = (state_ff == S_READ);

   bms_merge_core #(.CAPACITY(CAPACITY)) u_core (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .count   (fill_in),
      .wr_en   (accept && room),
      .wr_addr (fill_ff[IW-1:0]),
      .wr_data (req_byte_in),
      .rd_addr (out_k_ff[IW-1:0]),
      .rd_data (rd_data),
      .done    (sort_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         fill_ff      <= '0;
         drop_ff      <= 1'b0;
         out_k_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_COLLECT: begin
               if (accept) begin
                  fill_ff <= fill_in;
                  drop_ff <= drop_ff || !room;
                  if (req_last_in) begin
                     out_k_ff <= '0;
                     state_ff <= S_SORT;
                  end
               end
            end
            S_SORT: begin
               if (sort_done) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               rsp_byte_ff  <= rd_data;
               rsp_last_ff  <= (out_k_ff + CW'(1) == fill_ff);
               rsp_ovf_ff   <= drop_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_SHOW;
            end
            S_SHOW: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     // run finished, start a fresh one
                     fill_ff  <= '0;
                     drop_ff  <= 1'b0;
                     state_ff <= S_COLLECT;
                  end else begin
                     out_k_ff <= out_k_ff + CW'(1);
                     state_ff <= S_READ;
                  end
               end
            end
            default: begin
               state_ff <= S_COLLECT;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_byte_out = rsp_byte_ff;
   assign rsp_last_out = rsp_last_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

### hdl/bms_checker.sv
// port-level checker for the byte merge sorter, bound to the top level
// depends on bms_pkg and assert_macros.svh
`include "assert_macros.svh"

module bms_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [bms_pkg::BYTE_W-1:0] rsp_byte_out,
   input logic                       rsp_last_out,
   input logic                       rsp_overflow
);
   import bms_pkg::*;

   logic              in_run_ff;
   logic [BYTE_W-1:0] prev_byte_ff;
   logic              rsp_beat;

   assign rsp_beat = rsp_valid && rsp_ready;

   // remember the last byte sent inside the current run
   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff <= 1'b0;
      end else if (rsp_beat) begin
         in_run_ff    <= !rsp_last_out;
         prev_byte_ff <= rsp_byte_out;
      end
   end

   `BMS_ASSERT_ALWAYS(no_req_during_rsp, clock, reset, !(req_ready && rsp_valid))
   `BMS_ASSERT_NEXT(rsp_beat_held, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_byte_out) && $stable(rsp_last_out)
                    && $stable(rsp_overflow))
   `BMS_ASSERT_NEXT(ready_after_last, clock, reset, rsp_beat && rsp_last_out, req_ready)
   `BMS_ASSERT_IMPL(rsp_ascending, clock, reset, rsp_valid && in_run_ff,
                    rsp_byte_out >= prev_byte_ff)

endmodule

bind byte_merge_sorter_unit bms_checker u_bms_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_byte_out (rsp_byte_out),
   .rsp_last_out (rsp_last_out),
   .rsp_overflow (rsp_overflow)
);
